>>> sv/ttd_pkg.sv
// Shared constants, opcodes and an arithmetic helper for the time-triggered task dispatcher.
package ttd_pkg;

  localparam int MAX_TASKS = 8;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 2;
  localparam int SLOT_W    = 3;
  localparam int MASK_W    = 8;
  localparam int TCNT_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  localparam int DIV_BITS_PER_STEP = 2;
  localparam int DIV_STEPS         = DATA_W / DIV_BITS_PER_STEP;
  localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

  localparam int ENTRY_W = 2 * DATA_W;

  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_SUSPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_RESUME  = 2'd2;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT   = 2'd2;

  // one restoring-division bit: shift in b, subtract the divisor if it fits
  function automatic logic [DATA_W-1:0] rem_step(input logic [DATA_W-1:0] rem,
                                                  input logic              b,
                                                  input logic [DATA_W-1:0] d);
    logic [DATA_W:0] t;
    t = {rem, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[DATA_W-1:0];
  endfunction

endpackage

>>> sv/ttd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ttd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/time_triggered_task_dispatcher.sv
// Top level of the time-triggered task dispatcher: slot table walk and result register.
//
// Input channel (in_valid/in_stall) carries one word per operation: tick,
// suspend by id, resume by id or write slot. Every accepted word yields
// exactly one result word on the output channel (out_valid/out_stall):
// fire mask, elapsed time after the operation, and a found flag.
// Slot ids and periods sit in a single 8-entry RAM with a registered read;
// enable bits and elapsed time are in flip-flops.
// Steps from accept to result: write slot goes straight to the result;
// suspend/resume read and compare each slot in turn; tick walks the
// active slots, skipping a disabled one after its read, a zero period
// after its check, else running one RAM read plus a modulo unit that
// retires 2 quotient bits a cycle. One operation is in flight at a time;
// in_stall is high while it runs, and a new word can be taken while the
// previous result still waits in the output register.
// While the receiver stalls, the result holds and the block waits with the
// next finished result. Reset clears elapsed time, enable bits and the
// configuration registers to tick 1, cycle 1, count 0; the RAM is not
// cleared, so a slot must be written before it is used.
module time_triggered_task_dispatcher (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ttd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ttd_pkg::DATA_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ttd_pkg::OP_W-1:0]             in_opcode,
  input  logic [ttd_pkg::DATA_W-1:0]           in_task_id,
  input  logic [ttd_pkg::SLOT_W-1:0]           in_slot,
  input  logic [ttd_pkg::DATA_W-1:0]           in_period,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ttd_pkg::MASK_W-1:0]           out_fire_mask,
  output logic [ttd_pkg::DATA_W-1:0]           out_elapsed_time,
  output logic                                 out_found
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_TICK_RD  = 3'd1;
  localparam logic [2:0] S_TICK_CHK = 3'd2;
  localparam logic [2:0] S_DIV      = 3'd3;
  localparam logic [2:0] S_TFIN     = 3'd4;
  localparam logic [2:0] S_SRCH_RD  = 3'd5;
  localparam logic [2:0] S_SRCH_CHK = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]                        state_r, state_nxt;
  logic [ttd_pkg::DATA_W-1:0]        tick_period_r, tick_period_nxt;
  logic [ttd_pkg::DATA_W-1:0]        cycle_period_r, cycle_period_nxt;
  logic [ttd_pkg::TCNT_W-1:0]        task_count_r, task_count_nxt;
  logic [ttd_pkg::MAX_TASKS-1:0]     en_r, en_nxt;
  logic [ttd_pkg::DATA_W-1:0]        elapsed_r, elapsed_nxt;
  logic [ttd_pkg::DATA_W-1:0]        acc_r, acc_nxt;
  logic [ttd_pkg::DATA_W-1:0]        key_r, key_nxt;
  logic                              set_en_r, set_en_nxt;
  logic [ttd_pkg::IDX_W-1:0]         idx_r, idx_nxt;
  logic [ttd_pkg::CNT_W-1:0]         n_r, n_nxt;
  logic [ttd_pkg::MASK_W-1:0]        fire_r, fire_nxt;
  logic                              found_r, found_nxt;
  logic [ttd_pkg::DATA_W-1:0]        rem_r, rem_nxt;
  logic [ttd_pkg::DATA_W-1:0]        dvd_r, dvd_nxt;
  logic [ttd_pkg::DATA_W-1:0]        per_r, per_nxt;
  logic [ttd_pkg::DIV_CNT_W-1:0]     div_cnt_r, div_cnt_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [ttd_pkg::MASK_W-1:0]        out_fire_r, out_fire_nxt;
  logic [ttd_pkg::DATA_W-1:0]        out_elapsed_r, out_elapsed_nxt;
  logic                              out_found_r, out_found_nxt;

  logic                              in_accept;
  logic                              ram_we;
  logic [ttd_pkg::IDX_W-1:0]         ram_waddr;
  logic [ttd_pkg::ENTRY_W-1:0]       ram_wdata;
  logic [ttd_pkg::ENTRY_W-1:0]       ram_rdata;
  logic [ttd_pkg::DATA_W-1:0]        rd_id;
  logic [ttd_pkg::DATA_W-1:0]        rd_period;
  logic                              idx_last;
  logic [ttd_pkg::CNT_W-1:0]         n_clamp;
  logic                              slot_ok;
  logic [ttd_pkg::DATA_W-1:0]        rem_a;
  logic [ttd_pkg::DATA_W-1:0]        rem_b;
  logic                              out_free;

  ttd_ram #(
    .WIDTH (ttd_pkg::ENTRY_W),
    .DEPTH (ttd_pkg::MAX_TASKS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign rd_id     = ram_rdata[ttd_pkg::ENTRY_W-1:ttd_pkg::DATA_W];
  assign rd_period = ram_rdata[ttd_pkg::DATA_W-1:0];

  assign slot_ok   = ({{(ttd_pkg::DATA_W-ttd_pkg::SLOT_W){1'b0}}, in_slot}
                      < ttd_pkg::DATA_W'(ttd_pkg::MAX_TASKS));
  assign ram_we    = in_accept && (in_opcode == ttd_pkg::OP_WRITE) && slot_ok;
  assign ram_waddr = ttd_pkg::IDX_W'(in_slot);
  assign ram_wdata = {in_task_id, in_period};

  assign n_clamp = ({{(ttd_pkg::DATA_W-ttd_pkg::TCNT_W){1'b0}}, task_count_r}
                    > ttd_pkg::DATA_W'(ttd_pkg::MAX_TASKS))
                   ? ttd_pkg::CNT_W'(ttd_pkg::MAX_TASKS)
                   : ttd_pkg::CNT_W'(task_count_r);

  assign idx_last = ((ttd_pkg::CNT_W'(idx_r) + ttd_pkg::CNT_W'(1)) == n_r);

  assign rem_a = ttd_pkg::rem_step(rem_r, dvd_r[ttd_pkg::DATA_W-1], per_r);
  assign rem_b = ttd_pkg::rem_step(rem_a, dvd_r[ttd_pkg::DATA_W-2], per_r);

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt        = state_r;
    tick_period_nxt  = tick_period_r;
    cycle_period_nxt = cycle_period_r;
    task_count_nxt   = task_count_r;
    en_nxt           = en_r;
    elapsed_nxt      = elapsed_r;
    acc_nxt          = acc_r;
    key_nxt          = key_r;
    set_en_nxt       = set_en_r;
    idx_nxt          = idx_r;
    n_nxt            = n_r;
    fire_nxt         = fire_r;
    found_nxt        = found_r;
    rem_nxt          = rem_r;
    dvd_nxt          = dvd_r;
    per_nxt          = per_r;
    div_cnt_nxt      = div_cnt_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_fire_nxt     = out_fire_r;
    out_elapsed_nxt  = out_elapsed_r;
    out_found_nxt    = out_found_r;

    if (cfg_we) begin
      unique case (cfg_index)
        ttd_pkg::CFG_TICK_PERIOD:  tick_period_nxt  = cfg_data;
        ttd_pkg::CFG_CYCLE_PERIOD: cycle_period_nxt = cfg_data;
        ttd_pkg::CFG_TASK_COUNT:   task_count_nxt   = cfg_data[ttd_pkg::TCNT_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          fire_nxt   = '0;
          found_nxt  = 1'b0;
          idx_nxt    = '0;
          n_nxt      = n_clamp;
          key_nxt    = in_task_id;
          set_en_nxt = (in_opcode == ttd_pkg::OP_RESUME);
          acc_nxt    = elapsed_r + tick_period_r;
          unique case (in_opcode) inside
            ttd_pkg::OP_TICK: begin
              state_nxt = (n_clamp == '0) ? S_TFIN : S_TICK_RD;
            end
            ttd_pkg::OP_SUSPEND, ttd_pkg::OP_RESUME: begin
              state_nxt = (n_clamp == '0) ? S_DONE : S_SRCH_RD;
            end
            ttd_pkg::OP_WRITE: begin
              if (slot_ok) begin
                en_nxt[ram_waddr] = 1'b1;
              end
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_TICK_RD: begin
        if (en_r[idx_r]) begin
          state_nxt = S_TICK_CHK;
        end else if (idx_last) begin
          state_nxt = S_TFIN;
        end else begin
          idx_nxt = idx_r + ttd_pkg::IDX_W'(1);
        end
      end
      S_TICK_CHK: begin
        if (rd_period == '0) begin
          if (idx_last) begin
            state_nxt = S_TFIN;
          end else begin
            idx_nxt   = idx_r + ttd_pkg::IDX_W'(1);
            state_nxt = S_TICK_RD;
          end
        end else begin
          rem_nxt     = '0;
          dvd_nxt     = acc_r;
          per_nxt     = rd_period;
          div_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt     = rem_b;
        dvd_nxt     = dvd_r << ttd_pkg::DIV_BITS_PER_STEP;
        div_cnt_nxt = div_cnt_r + ttd_pkg::DIV_CNT_W'(1);
        if (div_cnt_r == ttd_pkg::DIV_CNT_W'(ttd_pkg::DIV_STEPS - 1)) begin
          if (rem_b == '0) begin
            fire_nxt = fire_r | (ttd_pkg::MASK_W'(1) << idx_r);
          end
          if (idx_last) begin
            state_nxt = S_TFIN;
          end else begin
            idx_nxt   = idx_r + ttd_pkg::IDX_W'(1);
            state_nxt = S_TICK_RD;
          end
        end
      end
      S_TFIN: begin
        elapsed_nxt = (acc_r == cycle_period_r) ? '0 : acc_r;
        state_nxt   = S_DONE;
      end
      S_SRCH_RD: begin
        state_nxt = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (rd_id == key_r) begin
          en_nxt[idx_r] = set_en_r;
          found_nxt     = 1'b1;
          state_nxt     = S_DONE;
        end else if (idx_last) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + ttd_pkg::IDX_W'(1);
          state_nxt = S_SRCH_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_fire_nxt    = fire_r;
          out_elapsed_nxt = elapsed_r;
          out_found_nxt   = found_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      tick_period_r  <= ttd_pkg::DATA_W'(1);
      cycle_period_r <= ttd_pkg::DATA_W'(1);
      task_count_r   <= '0;
      en_r           <= '0;
      elapsed_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      tick_period_r  <= tick_period_nxt;
      cycle_period_r <= cycle_period_nxt;
      task_count_r   <= task_count_nxt;
      en_r           <= en_nxt;
      elapsed_r      <= elapsed_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r         <= acc_nxt;
    key_r         <= key_nxt;
    set_en_r      <= set_en_nxt;
    idx_r         <= idx_nxt;
    n_r           <= n_nxt;
    fire_r        <= fire_nxt;
    found_r       <= found_nxt;
    rem_r         <= rem_nxt;
    dvd_r         <= dvd_nxt;
    per_r         <= per_nxt;
    div_cnt_r     <= div_cnt_nxt;
    out_fire_r    <= out_fire_nxt;
    out_elapsed_r <= out_elapsed_nxt;
    out_found_r   <= out_found_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_fire_mask    = out_fire_r;
  assign out_elapsed_time = out_elapsed_r;
  assign out_found        = out_found_r;

endmodule

>>> bench/time_triggered_task_dispatcher_tb.sv
// Self-checking testbench for the time-triggered task dispatcher: scoreboard with random stimulus.
module time_triggered_task_dispatcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ttd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_TICKS = 160;
  localparam int ID_POOL      = 6;
  localparam int OPS_PER_SET  = 100;

  typedef struct packed {
    logic [ttd_pkg::OP_W-1:0]   opcode;
    logic [ttd_pkg::DATA_W-1:0] task_id;
    logic [ttd_pkg::SLOT_W-1:0] slot;
    logic [ttd_pkg::DATA_W-1:0] period;
  } op_word_t;

  typedef struct packed {
    logic [ttd_pkg::MASK_W-1:0] fire_mask;
    logic [ttd_pkg::DATA_W-1:0] elapsed;
    logic                       found;
  } outcome_t;

  typedef enum logic {PER_HARMONIC, PER_ANY} period_mix_t;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [ttd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ttd_pkg::DATA_W-1:0]    cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic [ttd_pkg::OP_W-1:0]      in_opcode  = '0;
  logic [ttd_pkg::DATA_W-1:0]    in_task_id = '0;
  logic [ttd_pkg::SLOT_W-1:0]    in_slot    = '0;
  logic [ttd_pkg::DATA_W-1:0]    in_period  = '0;
  logic                          out_valid;
  logic                          out_stall  = 1'b1;
  logic [ttd_pkg::MASK_W-1:0]    out_fire_mask;
  logic [ttd_pkg::DATA_W-1:0]    out_elapsed_time;
  logic                          out_found;

  time_triggered_task_dispatcher dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_task_id      (in_task_id),
    .in_slot         (in_slot),
    .in_period       (in_period),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fire_mask   (out_fire_mask),
    .out_elapsed_time(out_elapsed_time),
    .out_found       (out_found)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the slot table, timer and registers
  logic [ttd_pkg::DATA_W-1:0] tbl_id     [ttd_pkg::MAX_TASKS];
  logic [ttd_pkg::DATA_W-1:0] tbl_period [ttd_pkg::MAX_TASKS];
  logic                       tbl_live   [ttd_pkg::MAX_TASKS];
  logic [ttd_pkg::DATA_W-1:0] elapsed_now = '0;
  logic [ttd_pkg::DATA_W-1:0] tick_step   = 32'd1;
  logic [ttd_pkg::DATA_W-1:0] wrap_point  = 32'd1;
  logic [ttd_pkg::TCNT_W-1:0] slots_used  = '0;

  op_word_t                   ops_to_send [$];
  outcome_t                   outcomes_due [$];
  logic [ttd_pkg::DATA_W-1:0] id_pool [ID_POOL];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned burst_left     = 0;
  int unsigned gap_left       = 0;
  int unsigned hold_left      = 0;
  int unsigned flow_left      = 0;
  bit          word_taken     = 1'b0;
  outcome_t    oldest;

  function automatic outcome_t dispatch_op(op_word_t w);
    outcome_t r;
    int live;
    logic hit;
    r = '0;
    hit = 1'b0;
    live = (slots_used > ttd_pkg::MAX_TASKS) ? ttd_pkg::MAX_TASKS : int'(slots_used);
    case (w.opcode) inside
      ttd_pkg::OP_TICK: begin
        elapsed_now = elapsed_now + tick_step;
        for (int i = 0; i < live; i++) begin
          if (i < ttd_pkg::MASK_W && tbl_live[i] && tbl_period[i] != '0 &&
              (elapsed_now % tbl_period[i]) == '0) begin
            r.fire_mask[i] = 1'b1;
          end
        end
        if (elapsed_now == wrap_point) begin
          elapsed_now = '0;
        end
      end
      ttd_pkg::OP_SUSPEND, ttd_pkg::OP_RESUME: begin
        for (int i = 0; i < live; i++) begin
          if (!hit && tbl_id[i] == w.task_id) begin
            tbl_live[i] = (w.opcode == ttd_pkg::OP_RESUME);
            hit = 1'b1;
          end
        end
        r.found = hit;
      end
      ttd_pkg::OP_WRITE: begin
        tbl_id[w.slot]     = w.task_id;
        tbl_period[w.slot] = w.period;
        tbl_live[w.slot]   = 1'b1;
      end
    endcase
    r.elapsed = elapsed_now;
    return r;
  endfunction

  function automatic op_word_t mk_word(logic [ttd_pkg::OP_W-1:0] op,
                                       logic [ttd_pkg::DATA_W-1:0] id,
                                       logic [ttd_pkg::SLOT_W-1:0] slot,
                                       logic [ttd_pkg::DATA_W-1:0] per);
    op_word_t w;
    w.opcode  = op;
    w.task_id = id;
    w.slot    = slot;
    w.period  = per;
    return w;
  endfunction

  function automatic op_word_t random_word(period_mix_t mix, logic [ttd_pkg::DATA_W-1:0] step);
    op_word_t w;
    int unsigned pick;
    int unsigned k;
    w.task_id = ($urandom_range(0, 3) != 0) ? id_pool[$urandom_range(0, ID_POOL - 1)]
                                             : $urandom();
    w.slot    = ttd_pkg::SLOT_W'($urandom_range(0, ttd_pkg::MAX_TASKS - 1));
    w.period  = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      w.opcode = ttd_pkg::OP_TICK;
    end else if (pick < 65) begin
      w.opcode = ttd_pkg::OP_SUSPEND;
    end else if (pick < 80) begin
      w.opcode = ttd_pkg::OP_RESUME;
    end else begin
      w.opcode = ttd_pkg::OP_WRITE;
      if (mix == PER_HARMONIC) begin
        case ($urandom_range(0, 6))
          0: k = 1;
          1: k = 2;
          2: k = 3;
          3: k = 4;
          4: k = 6;
          5: k = 12;
          default: k = 0;
        endcase
        w.period = step * ttd_pkg::DATA_W'(k);
      end else begin
        case ($urandom_range(0, 7))
          0: w.period = '0;
          1: w.period = '1;
          2: w.period = 32'd1;
          default: w.period = $urandom();
        endcase
      end
    end
    return w;
  endfunction

  task automatic cfg_write(logic [ttd_pkg::CFG_IDX_W-1:0] idx, logic [ttd_pkg::DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      ttd_pkg::CFG_TICK_PERIOD:  tick_step  = val;
      ttd_pkg::CFG_CYCLE_PERIOD: wrap_point = val;
      ttd_pkg::CFG_TASK_COUNT:   slots_used = val[ttd_pkg::TCNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (ops_to_send.size() != 0 || outcomes_due.size() != 0 || in_valid) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // align the timer to the new cycle with one tick, then run random words
  task automatic run_set(logic [ttd_pkg::DATA_W-1:0] step, logic [ttd_pkg::DATA_W-1:0] wrap,
                         logic [ttd_pkg::TCNT_W-1:0] count, period_mix_t mix,
                         int unsigned n_ops);
    cfg_write(ttd_pkg::CFG_CYCLE_PERIOD, wrap);
    cfg_write(ttd_pkg::CFG_TASK_COUNT, ttd_pkg::DATA_W'(count));
    cfg_write(ttd_pkg::CFG_TICK_PERIOD, wrap - elapsed_now);
    ops_to_send.push_back(mk_word(ttd_pkg::OP_TICK, $urandom(), 3'd0, $urandom()));
    drain();
    cfg_write(ttd_pkg::CFG_TICK_PERIOD, step);
    repeat (n_ops) ops_to_send.push_back(random_word(mix, step));
    drain();
  endtask

  function automatic void note_mismatch(string what, logic [ttd_pkg::DATA_W-1:0] want,
                                        logic [ttd_pkg::DATA_W-1:0] got);
    mismatch_count++;
    $display("%0t: %s expected %h got %h", $time, what, want, got);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      outcomes_due.push_back(dispatch_op(ops_to_send.pop_front()));
      word_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!(in_valid && !word_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (ops_to_send.size() != 0) begin
        in_valid   <= 1'b1;
        in_opcode  <= ops_to_send[0].opcode;
        in_task_id <= ops_to_send[0].task_id;
        in_slot    <= ops_to_send[0].slot;
        in_period  <= ops_to_send[0].period;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
    word_taken = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (flow_left != 0) begin
      flow_left--;
      out_stall <= 1'b0;
    end else begin
      flow_left = $urandom_range(0, 40);
      hold_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (outcomes_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none pending: expected nothing got %s %h %h %b",
                 $time, "mask/elapsed/found", out_fire_mask, out_elapsed_time, out_found);
      end else begin
        oldest = outcomes_due.pop_front();
        if (out_fire_mask !== oldest.fire_mask) begin
          note_mismatch("fire_mask", ttd_pkg::DATA_W'(oldest.fire_mask),
                        ttd_pkg::DATA_W'(out_fire_mask));
        end
        if (out_elapsed_time !== oldest.elapsed) begin
          note_mismatch("elapsed_time", oldest.elapsed, out_elapsed_time);
        end
        if (out_found !== oldest.found) begin
          note_mismatch("found", ttd_pkg::DATA_W'(oldest.found), ttd_pkg::DATA_W'(out_found));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("time_triggered_task_dispatcher verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < ttd_pkg::MAX_TASKS; i++) begin
      tbl_id[i]     = '0;
      tbl_period[i] = '0;
      tbl_live[i]   = 1'b0;
    end
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    id_pool[2] = 32'hA5A5_A5A5;
    id_pool[3] = 32'h5A5A_5A5A;
    id_pool[4] = 32'd7;
    id_pool[5] = $urandom();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no slots in use yet: searches miss, then fill every slot beyond the count
    ops_to_send.push_back(mk_word(ttd_pkg::OP_TICK,    32'h0,         3'd0, 32'h0));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_SUSPEND, 32'h0,         3'd0, 32'h0));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_RESUME,  32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_WRITE, 32'h0000_0000, 3'd0, 32'd1));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_WRITE, 32'hFFFF_FFFF, 3'd1, 32'hFFFF_FFFF));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_WRITE, 32'hA5A5_A5A5, 3'd2, 32'd0));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_WRITE, 32'h5A5A_5A5A, 3'd3, 32'd2));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_WRITE, 32'hA5A5_A5A5, 3'd4, 32'd3));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_WRITE, 32'd7,         3'd5, 32'd4));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_WRITE, 32'd8,         3'd6, 32'd6));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_WRITE, 32'd9,         3'd7, 32'd12));
    drain();

    // count above the table size, duplicate ids, zero period
    cfg_write(ttd_pkg::CFG_TASK_COUNT, 32'd15);
    cfg_write(ttd_pkg::CFG_CYCLE_PERIOD, 32'd12);
    ops_to_send.push_back(mk_word(ttd_pkg::OP_TICK,    32'h0,         3'd0, 32'h0));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_TICK,    32'h0,         3'd0, 32'h0));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_SUSPEND, 32'hA5A5_A5A5, 3'd0, 32'h0));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_TICK,    32'h0,         3'd0, 32'h0));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_RESUME,  32'hA5A5_A5A5, 3'd0, 32'h0));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_SUSPEND, 32'hFFFF_FFFF, 3'd0, 32'h0));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_SUSPEND, 32'h1234_5678, 3'd0, 32'h0));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_TICK,    32'h0,         3'd0, 32'h0));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_RESUME,  32'hFFFF_FFFF, 3'd0, 32'h0));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_TICK,    32'h0,         3'd0, 32'h0));
    drain();

    // zero tick period, slot beyond a reduced count, write to the spare index
    cfg_write(ttd_pkg::CFG_TASK_COUNT, 32'd3);
    cfg_write(ttd_pkg::CFG_TICK_PERIOD, 32'd0);
    cfg_write(CFG_SPARE, 32'hFFFF_FFFF);
    ops_to_send.push_back(mk_word(ttd_pkg::OP_TICK,    32'h0, 3'd0, 32'h0));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_SUSPEND, 32'd7, 3'd0, 32'h0));
    ops_to_send.push_back(mk_word(ttd_pkg::OP_TICK,    32'h0, 3'd0, 32'h0));
    drain();

    run_set(32'd1, 32'd12, 4'd8, PER_HARMONIC, OPS_PER_SET);
    run_set(32'd3, 32'd36, ttd_pkg::TCNT_W'($urandom_range(1, 7)), PER_HARMONIC,
            OPS_PER_SET);
    run_set(32'h1000_0000, 32'hFFFF_FFFF, 4'd15, PER_HARMONIC, OPS_PER_SET);
    run_set(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd8, PER_ANY, OPS_PER_SET);
    run_set($urandom_range(2, 1000) * 32'd12 / 32'd12, 32'd0, 4'd0, PER_ANY, OPS_PER_SET / 4);
    run_set($urandom(), $urandom(), ttd_pkg::TCNT_W'($urandom_range(0, 8)), PER_ANY,
            OPS_PER_SET);
    run_set(32'd5, 32'd60, 4'd8, PER_HARMONIC, OPS_PER_SET);

    repeat (SETTLE_TICKS) @(negedge clk);
    if (mismatch_count == 0 && outcomes_due.size() == 0) begin
      $display("time_triggered_task_dispatcher verification clean");
    end else begin
      $display("time_triggered_task_dispatcher verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/ttd_pkg.sv
sv/ttd_ram.sv
sv/time_triggered_task_dispatcher.sv
bench/time_triggered_task_dispatcher_tb.sv
